@@ rtl/lhce_pkg.sv @@
// lhce_pkg: shared constants and types for the light attribute colour engine
// used by every rtl module of the engine but lhce_smul, and by its checker
// no dependencies
`default_nettype none

package lhce_pkg;

    // channel count and index width
    localparam int NUM_CHANNELS = 2;
    localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // attribute decode codes
    localparam logic [15:0] CL_ON_OFF  = 16'h0006;
    localparam logic [15:0] CL_LEVEL   = 16'h0008;
    localparam logic [15:0] CL_COLOUR  = 16'h0300;
    localparam logic [15:0] ATTR_MAIN  = 16'h0000;
    localparam logic [15:0] ATTR_SAT   = 16'h0001;
    localparam logic [7:0]  TYPE_BOOL  = 8'h10;
    localparam logic [7:0]  TYPE_U8    = 8'h20;

    // reset values of register and channel state
    localparam logic [7:0]  BASE_EP_RST = 8'd10;
    localparam logic [7:0]  LEVEL_RST   = 8'd128;
    localparam logic [7:0]  HUE_RST     = 8'd0;
    localparam logic [7:0]  SAT_RST     = 8'd254;

    // hue scaling: hue*360/254, then split in 60 degree sectors
    localparam logic [8:0]  HUE_DIV     = 9'd254;
    localparam logic [8:0]  SEG_DIV     = 9'd60;
    localparam logic [3:0]  HUE_Q_LAST  = 4'd8;   // nine quotient bits
    localparam logic [3:0]  SEG_Q_LAST  = 4'd2;   // three quotient bits

    // serial multiplier: one multiplier bit per cycle
    localparam logic [2:0]  MUL_LAST    = 3'd7;

    // hue sectors
    localparam logic [2:0]  SEC_RED_YEL = 3'd0;
    localparam logic [2:0]  SEC_YEL_GRN = 3'd1;
    localparam logic [2:0]  SEC_GRN_CYN = 3'd2;
    localparam logic [2:0]  SEC_CYN_BLU = 3'd3;
    localparam logic [2:0]  SEC_BLU_MAG = 3'd4;

    // configuration port
    localparam int          APB_AW      = 3;
    localparam int          APB_DW      = 32;
    localparam logic        REG_BASE_EP = 1'b0;  // word index of base_endpoint

    // stream widths
    localparam int IN_DATA_W  = 56;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 3;

    typedef struct packed {
        logic        status_ok;
        logic [7:0]  endpoint;
        logic [15:0] cluster_id;
        logic [15:0] attribute_id;
        logic [7:0]  data_type;
        logic        value_present;
        logic [7:0]  value;
    } t_item;

    // decoded event and channel state after the update
    typedef struct packed {
        logic        changed;
        logic        fault;
        logic        channel;
        logic        light_on;
        logic [7:0]  hue;
        logic [7:0]  sat;
        logic [7:0]  level;
    } t_view;

endpackage

`default_nettype wire

@@ rtl/lhce_chan.sv @@
// lhce_chan: attribute decode and per-channel light state
// depends on lhce_pkg
`default_nettype none

module lhce_chan import lhce_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_commit,
    input  logic [7:0]  i_base_ep,
    input  t_item       i_item,
    output t_view       o_view
);

    logic              r_on    [NUM_CHANNELS];
    logic [7:0]        r_level [NUM_CHANNELS];
    logic [7:0]        r_hue   [NUM_CHANNELS];
    logic [7:0]        r_sat   [NUM_CHANNELS];
    t_view             r_view;
    t_view             n_view;

    logic [7:0]        idx;
    logic              known;
    logic [CH_W-1:0]   sel;
    logic              wr_on;
    logic              wr_lvl;
    logic              wr_hue;
    logic              wr_sat;
    logic              put;

    always_comb begin
        idx   = i_item.endpoint - i_base_ep;
        known = i_item.status_ok && (idx < 8'(NUM_CHANNELS));
        sel   = known ? idx[CH_W-1:0] : '0;
        put   = i_item.value_present;

        wr_on  = known && (i_item.cluster_id == CL_ON_OFF)
                 && (i_item.attribute_id == ATTR_MAIN) && (i_item.data_type == TYPE_BOOL);
        wr_lvl = known && (i_item.cluster_id == CL_LEVEL)
                 && (i_item.attribute_id == ATTR_MAIN) && (i_item.data_type == TYPE_U8);
        wr_hue = known && (i_item.cluster_id == CL_COLOUR)
                 && (i_item.attribute_id == ATTR_MAIN) && (i_item.data_type == TYPE_U8);
        wr_sat = known && (i_item.cluster_id == CL_COLOUR)
                 && (i_item.attribute_id == ATTR_SAT) && (i_item.data_type == TYPE_U8);

        n_view.changed  = wr_on || wr_lvl || wr_hue || wr_sat;
        n_view.fault    = !i_item.status_ok;
        n_view.channel  = known ? idx[0] : 1'b0;
        n_view.light_on = (wr_on && put) ? (i_item.value != 8'd0) : r_on[sel];
        n_view.level    = (wr_lvl && put) ? i_item.value : r_level[sel];
        n_view.hue      = (wr_hue && put) ? i_item.value : r_hue[sel];
        n_view.sat      = (wr_sat && put) ? i_item.value : r_sat[sel];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_on[i]    <= 1'b0;
                r_level[i] <= LEVEL_RST;
                r_hue[i]   <= HUE_RST;
                r_sat[i]   <= SAT_RST;
            end
        end else if (i_commit && put) begin
            if (wr_on) begin
                r_on[sel] <= n_view.light_on;
            end
            if (wr_lvl) begin
                r_level[sel] <= n_view.level;
            end
            if (wr_hue) begin
                r_hue[sel] <= n_view.hue;
            end
            if (wr_sat) begin
                r_sat[sel] <= n_view.sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_commit) begin
            r_view <= n_view;
        end
    end

    assign o_view = r_view;

endmodule

`default_nettype wire

@@ rtl/lhce_huediv.sv @@
// lhce_huediv: bit-serial hue scaling and sector split
// restoring division, one quotient bit per cycle; depends on lhce_pkg
`default_nettype none

module lhce_huediv import lhce_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [7:0]  i_hue,
    output logic        o_busy,
    output logic [2:0]  o_region,
    output logic [7:0]  o_rem
);

    typedef enum logic [2:0] {
        DV_IDLE  = 3'b001,
        DV_SCALE = 3'b010,
        DV_SEG   = 3'b100
    } t_div_state;

    t_div_state  r_state;
    logic [3:0]  r_cnt;
    logic [7:0]  r_rem;
    logic [8:0]  r_num;

    logic [16:0] hue_x;
    logic [16:0] scaled;
    logic [8:0]  divisor;
    logic [8:0]  trial;
    logic [8:0]  diff;
    logic        q_bit;
    logic [7:0]  n_rem;
    logic [8:0]  n_num;
    logic [9:0]  rem_x17;

    always_comb begin
        // hue * 360 as a sum of shifts
        hue_x   = 17'(i_hue);
        scaled  = (hue_x << 8) + (hue_x << 6) + (hue_x << 5) + (hue_x << 3);
        divisor = (r_state == DV_SEG) ? SEG_DIV : HUE_DIV;
        trial   = {r_rem, r_num[8]};
        diff    = trial - divisor;
        q_bit   = (trial >= divisor);
        n_rem   = q_bit ? diff[7:0] : trial[7:0];
        n_num   = {r_num[7:0], q_bit};
        // (sector remainder * 17) >> 2
        rem_x17 = {r_rem[5:0], 4'b0000} + {4'b0000, r_rem[5:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                DV_IDLE: begin
                    if (i_start) begin
                        r_rem   <= scaled[16:9];
                        r_num   <= scaled[8:0];
                        r_cnt   <= '0;
                        r_state <= DV_SCALE;
                    end
                end
                DV_SCALE: begin
                    if (r_cnt == HUE_Q_LAST) begin
                        // quotient done: reload as scaled hue / 60
                        r_rem   <= {2'b00, n_num[8:3]};
                        r_num   <= {n_num[2:0], 6'b000000};
                        r_cnt   <= '0;
                        r_state <= DV_SEG;
                    end else begin
                        r_rem <= n_rem;
                        r_num <= n_num;
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                DV_SEG: begin
                    r_rem <= n_rem;
                    r_num <= n_num;
                    if (r_cnt == SEG_Q_LAST) begin
                        r_state <= DV_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                default: begin
                    r_state <= DV_IDLE;
                end
            endcase
        end
    end

    assign o_busy   = (r_state != DV_IDLE);
    assign o_region = r_num[2:0];
    assign o_rem    = rem_x17[9:2];

endmodule

`default_nettype wire

@@ rtl/lhce_smul.sv @@
// lhce_smul: bit-serial 8x8 shift-add multiplier lane
// one multiplier bit per step, high byte of the product out; no dependencies
`default_nettype none

module lhce_smul (
    input  logic        i_clk,
    input  logic        i_load,
    input  logic        i_step,
    input  logic [7:0]  i_a,
    input  logic [7:0]  i_b,
    output logic [7:0]  o_hi
);

    logic [7:0] r_a;
    logic [7:0] r_hi;
    logic [7:0] r_lo;
    logic [8:0] psum;

    assign psum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : 9'd0);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (i_step) begin
            r_hi <= psum[8:1];
            r_lo <= {psum[0], r_lo[7:1]};
        end
    end

    assign o_hi = r_hi;

endmodule

`default_nettype wire

@@ rtl/light_attribute_hsv_color_engine_top.sv @@
// light_attribute_hsv_color_engine_top: attribute write decode and hsv to rgb colour
// one word at a time: a word passes decode, the serial hue divider (12 steps) and two
// 8-step multiplier passes before its result is loaded and the next word is taken
// the result register lets the next word in while a result still waits downstream
// reset: synchronous active low; channels off, level 128, hue 0, saturation 254,
// base endpoint 10, no result pending
`default_nettype none

module light_attribute_hsv_color_engine_top import lhce_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    // attribute write words
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // endpoint[7:0], cluster_id[23:8], attribute_id[39:24], data_type[47:40], value[55:48]
    input  logic [IN_DATA_W-1:0]   i_s_axis_tdata,
    // status_ok[0], value_present[1]
    input  logic [IN_USER_W-1:0]   i_s_axis_tuser,

    // colour result words
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // red[7:0], green[15:8], blue[23:16]
    output logic [OUT_DATA_W-1:0]  o_m_axis_tdata,
    // channel[0], changed[1], fault[2]
    output logic [OUT_USER_W-1:0]  o_m_axis_tuser,

    // register port
    input  logic                   i_psel,
    input  logic                   i_penable,
    input  logic                   i_pwrite,
    input  logic [APB_AW-1:0]      i_paddr,
    input  logic [APB_DW-1:0]      i_pwdata,
    output logic [APB_DW-1:0]      o_prdata,
    output logic                   o_pready
);

    // sequencer: one word at a time through decode, hue split and two multiply passes
    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_DECODE = 8'b0000_0010,
        ST_START  = 8'b0000_0100,
        ST_HUE    = 8'b0000_1000,
        ST_MUL1   = 8'b0001_0000,
        ST_LOAD2  = 8'b0010_0000,
        ST_MUL2   = 8'b0100_0000,
        ST_OUT    = 8'b1000_0000
    } t_state;

    t_state                  r_state;
    t_state                  n_state;
    logic [2:0]              r_cnt;
    logic [2:0]              n_cnt;
    logic [7:0]              r_base_ep;
    t_item                   r_item;
    logic                    r_out_valid;
    logic [OUT_DATA_W-1:0]   r_out_data;
    logic [OUT_USER_W-1:0]   r_out_user;

    t_item                   in_item;
    logic                    in_acc;
    logic                    cfg_wr;
    logic                    out_ld;
    t_view                   view;

    logic                    div_busy;
    logic [2:0]              region;
    logic [7:0]              hue_rem;

    logic                    load_1;
    logic                    load_2;
    logic                    step_1;
    logic                    step_2;
    logic [7:0]              lane_a;
    logic [7:0]              b0;
    logic [7:0]              b1;
    logic [7:0]              hi0;
    logic [7:0]              hi1;
    logic [7:0]              hi2;
    logic [7:0]              red;
    logic [7:0]              green;
    logic [7:0]              blue;

    // ---------------- register port ----------------
    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready;
    // word index sits above the byte offset
    assign o_prdata = (i_paddr[2] == REG_BASE_EP) ? {24'd0, r_base_ep} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_ep <= BASE_EP_RST;
        end else if (cfg_wr && (i_paddr[2] == REG_BASE_EP)) begin
            r_base_ep <= i_pwdata[7:0];
        end
    end

    // ---------------- input side ----------------
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        in_item.status_ok     = i_s_axis_tuser[0];
        in_item.value_present = i_s_axis_tuser[1];
        in_item.endpoint      = i_s_axis_tdata[7:0];
        in_item.cluster_id    = i_s_axis_tdata[23:8];
        in_item.attribute_id  = i_s_axis_tdata[39:24];
        in_item.data_type     = i_s_axis_tdata[47:40];
        in_item.value         = i_s_axis_tdata[55:48];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= in_item;
        end
    end

    // decode and channel state, updated once per word in the decode cycle
    lhce_chan u_chan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_commit  (r_state == ST_DECODE),
        .i_base_ep (r_base_ep),
        .i_item    (r_item),
        .o_view    (view)
    );

    // hue -> sector and scaled remainder, one quotient bit per cycle
    lhce_huediv u_huediv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == ST_START),
        .i_hue    (view.hue),
        .o_busy   (div_busy),
        .o_region (region),
        .o_rem    (hue_rem)
    );

    // ---------------- multiplier lanes ----------------
    // pass 1: lane0 s*rem, lane1 s*(255-rem), lane2 v*(255-s) = p
    // pass 2: lane0 v*(255-a0) = q, lane1 v*(255-a1) = t, lane2 keeps p
    assign load_1 = (r_state == ST_HUE) && !div_busy;
    assign load_2 = (r_state == ST_LOAD2);
    assign step_1 = (r_state == ST_MUL1);
    assign step_2 = (r_state == ST_MUL2);
    assign lane_a = load_2 ? view.level : view.sat;
    assign b0     = load_2 ? ~hi0 : hue_rem;
    assign b1     = load_2 ? ~hi1 : ~hue_rem;

    lhce_smul u_lane0 (
        .i_clk  (i_clk),
        .i_load (load_1 || load_2),
        .i_step (step_1 || step_2),
        .i_a    (lane_a),
        .i_b    (b0),
        .o_hi   (hi0)
    );

    lhce_smul u_lane1 (
        .i_clk  (i_clk),
        .i_load (load_1 || load_2),
        .i_step (step_1 || step_2),
        .i_a    (lane_a),
        .i_b    (b1),
        .o_hi   (hi1)
    );

    lhce_smul u_lane2 (
        .i_clk  (i_clk),
        .i_load (load_1),
        .i_step (step_1),
        .i_a    (view.level),
        .i_b    (~view.sat),
        .o_hi   (hi2)
    );

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_state = ST_START;
            end
            ST_START: begin
                n_state = ST_HUE;
            end
            ST_HUE: begin
                if (!div_busy) begin
                    n_state = ST_MUL1;
                    n_cnt   = '0;
                end
            end
            ST_MUL1: begin
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == MUL_LAST) begin
                    n_state = ST_LOAD2;
                end
            end
            ST_LOAD2: begin
                n_state = ST_MUL2;
                n_cnt   = '0;
            end
            ST_MUL2: begin
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == MUL_LAST) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_ld) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // ---------------- colour select ----------------
    // p = hi2, q = hi0, t = hi1; black unless updated and switched on
    always_comb begin
        red   = '0;
        green = '0;
        blue  = '0;
        if (view.changed && view.light_on) begin
            case (region)
                SEC_RED_YEL: begin
                    red = view.level; green = hi1;        blue = hi2;
                end
                SEC_YEL_GRN: begin
                    red = hi0;        green = view.level; blue = hi2;
                end
                SEC_GRN_CYN: begin
                    red = hi2;        green = view.level; blue = hi1;
                end
                SEC_CYN_BLU: begin
                    red = hi2;        green = hi0;        blue = view.level;
                end
                SEC_BLU_MAG: begin
                    red = hi1;        green = hi2;        blue = view.level;
                end
                default: begin
                    // last sector, also the scaled hue of 360 and 361
                    red = view.level; green = hi2;        blue = hi0;
                end
            endcase
        end
    end

    // ---------------- output register ----------------
    assign out_ld = (r_state == ST_OUT) && (!r_out_valid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ld) begin
            r_out_data <= {blue, green, red};
            r_out_user <= {view.fault, view.changed, view.channel};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule

`default_nettype wire

@@ rtl/lhce_checker.sv @@
// lhce_checker: port-level assertions for the light attribute colour engine
// bound to light_attribute_hsv_color_engine_top; depends on lhce_pkg
`default_nettype none

module lhce_checker import lhce_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    input  logic                   o_s_axis_tready,
    input  logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    input  logic [OUT_DATA_W-1:0]  o_m_axis_tdata,
    input  logic [OUT_USER_W-1:0]  o_m_axis_tuser
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready
        |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result word changed while stalled");

    // one word in flight: no second acceptance right after one
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("word accepted while previous one still in work");

    // failed status gives no update, channel zero and black
    a_fault_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[2]
        |-> (o_m_axis_tuser[1:0] == 2'b00) && (o_m_axis_tdata == '0))
        else $error("fault result carries channel, update or colour");

    // no update means no colour
    a_nochange_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[1] |-> (o_m_axis_tdata == '0))
        else $error("colour reported without an update");

    // nothing pending straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind light_attribute_hsv_color_engine_top lhce_checker u_lhce_checker (.*);

`default_nettype wire

@@ bench/hsv_colour_checker.sv @@
// hsv_colour_checker: watches the attribute and colour streams of the colour engine,
// keeps its own copy of the channel state and compares every colour word in order
// depends on lhce_pkg for stream widths, decode codes and reset values
`timescale 1ns / 100ps

module hsv_colour_checker import lhce_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    input  logic                   i_s_axis_tready,
    // endpoint[7:0], cluster_id[23:8], attribute_id[39:24], data_type[47:40], value[55:48]
    input  logic [IN_DATA_W-1:0]   i_s_axis_tdata,
    // status_ok[0], value_present[1]
    input  logic [IN_USER_W-1:0]   i_s_axis_tuser,
    input  logic                   i_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // red[7:0], green[15:8], blue[23:16]
    input  logic [OUT_DATA_W-1:0]  i_m_axis_tdata,
    // channel[0], changed[1], fault[2]
    input  logic [OUT_USER_W-1:0]  i_m_axis_tuser,
    input  logic                   i_psel,
    input  logic                   i_penable,
    input  logic                   i_pwrite,
    input  logic                   i_pready,
    input  logic [APB_AW-1:0]      i_paddr,
    input  logic [APB_DW-1:0]      i_pwdata,
    output int                     o_mismatches,
    output int                     o_outstanding
);

    localparam logic [APB_AW-1:0] BASE_EP_ADDR = APB_AW'({REG_BASE_EP, 2'b00});

    typedef struct packed {
        logic       channel;
        logic       changed;
        logic       fault;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_colour;

    logic [7:0] base_ep;
    logic       lamp_on    [NUM_CHANNELS];
    logic [7:0] lamp_level [NUM_CHANNELS];
    logic [7:0] lamp_hue   [NUM_CHANNELS];
    logic [7:0] lamp_sat   [NUM_CHANNELS];
    t_colour    colour_due_q [$];
    int         mismatches = 0;

    assign o_mismatches = mismatches;

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        $display("%0t colour word mismatch on %s: got %0d, want %0d", $realtime, field,
                 got, want);
        mismatches++;
    endtask

    function automatic t_colour hsv_colour(input logic [7:0] h, input logic [7:0] s,
                                           input logic [7:0] v);
        int unsigned deg, sector, frac, p, q, t;
        t_colour     c;
        c      = '0;
        deg    = (int'(h) * 360) / 254;
        sector = deg / 60;
        // sector fraction scaled to 0..250
        frac   = ((deg % 60) * 17) >> 2;
        p      = (int'(v) * (255 - int'(s))) >> 8;
        q      = (int'(v) * (255 - ((int'(s) * frac) >> 8))) >> 8;
        t      = (int'(v) * (255 - ((int'(s) * (255 - frac)) >> 8))) >> 8;
        case (sector)
            SEC_RED_YEL: begin c.red = v;      c.green = t[7:0]; c.blue = p[7:0]; end
            SEC_YEL_GRN: begin c.red = q[7:0]; c.green = v;      c.blue = p[7:0]; end
            SEC_GRN_CYN: begin c.red = p[7:0]; c.green = v;      c.blue = t[7:0]; end
            SEC_CYN_BLU: begin c.red = p[7:0]; c.green = q[7:0]; c.blue = v;      end
            SEC_BLU_MAG: begin c.red = t[7:0]; c.green = p[7:0]; c.blue = v;      end
            // last sector, also hue 254 and 255 scaling to 360 and 361
            default:     begin c.red = v;      c.green = p[7:0]; c.blue = q[7:0]; end
        endcase
        return c;
    endfunction

    // applies one attribute write to the channel copy and returns its colour word
    function automatic t_colour predict_colour(input t_item it);
        logic [7:0]      offs;
        logic [CH_W-1:0] ch;
        logic            hit;
        t_colour         res;
        t_colour         rgb;
        res = '0;
        hit = 1'b0;
        offs = it.endpoint - base_ep;
        if (!it.status_ok) begin
            res.fault = 1'b1;
        end else if (offs < NUM_CHANNELS) begin
            ch = offs[CH_W-1:0];
            case (it.cluster_id)
                CL_ON_OFF: begin
                    if (it.attribute_id == ATTR_MAIN && it.data_type == TYPE_BOOL) begin
                        if (it.value_present) lamp_on[ch] = (it.value != 8'd0);
                        hit = 1'b1;
                    end
                end
                CL_LEVEL: begin
                    if (it.attribute_id == ATTR_MAIN && it.data_type == TYPE_U8) begin
                        if (it.value_present) lamp_level[ch] = it.value;
                        hit = 1'b1;
                    end
                end
                CL_COLOUR: begin
                    if (it.data_type == TYPE_U8 && it.attribute_id == ATTR_MAIN) begin
                        if (it.value_present) lamp_hue[ch] = it.value;
                        hit = 1'b1;
                    end else if (it.data_type == TYPE_U8 && it.attribute_id == ATTR_SAT) begin
                        if (it.value_present) lamp_sat[ch] = it.value;
                        hit = 1'b1;
                    end
                end
                default: ;
            endcase
            res.channel = offs[0];
            if (hit) begin
                res.changed = 1'b1;
                if (lamp_on[ch]) begin
                    rgb       = hsv_colour(lamp_hue[ch], lamp_sat[ch], lamp_level[ch]);
                    res.red   = rgb.red;
                    res.green = rgb.green;
                    res.blue  = rgb.blue;
                end
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_item   it;
        t_colour got;
        t_colour want;
        if (!i_rst_n) begin
            base_ep = BASE_EP_RST;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                lamp_on[i]    = 1'b0;
                lamp_level[i] = LEVEL_RST;
                lamp_hue[i]   = HUE_RST;
                lamp_sat[i]   = SAT_RST;
            end
            colour_due_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == BASE_EP_ADDR)
                base_ep = i_pwdata[7:0];
            // compare before predicting so a word never meets its own expectation
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.channel = i_m_axis_tuser[0];
                got.changed = i_m_axis_tuser[1];
                got.fault   = i_m_axis_tuser[2];
                got.red     = i_m_axis_tdata[7:0];
                got.green   = i_m_axis_tdata[15:8];
                got.blue    = i_m_axis_tdata[23:16];
                if (colour_due_q.size() == 0) begin
                    report_mismatch("unexpected word", 32'(got), 0);
                end else begin
                    want = colour_due_q.pop_front();
                    if (got.channel != want.channel)
                        report_mismatch("channel", got.channel, want.channel);
                    if (got.changed != want.changed)
                        report_mismatch("changed", got.changed, want.changed);
                    if (got.fault != want.fault)
                        report_mismatch("fault", got.fault, want.fault);
                    if (got.red != want.red)
                        report_mismatch("red", got.red, want.red);
                    if (got.green != want.green)
                        report_mismatch("green", got.green, want.green);
                    if (got.blue != want.blue)
                        report_mismatch("blue", got.blue, want.blue);
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                it.status_ok     = i_s_axis_tuser[0];
                it.value_present = i_s_axis_tuser[1];
                it.endpoint      = i_s_axis_tdata[7:0];
                it.cluster_id    = i_s_axis_tdata[23:8];
                it.attribute_id  = i_s_axis_tdata[39:24];
                it.data_type     = i_s_axis_tdata[47:40];
                it.value         = i_s_axis_tdata[55:48];
                colour_due_q.push_back(predict_colour(it));
            end
        end
        o_outstanding <= colour_due_q.size();
    end

endmodule

@@ bench/tb_light_attribute_hsv_color_engine_top.sv @@
// tb_light_attribute_hsv_color_engine_top: stimulus and verdict for the colour engine
// drives attribute words, register writes and a throttled result sink
// depends on lhce_pkg, the engine top and hsv_colour_checker
`timescale 1ns / 100ps

module tb_light_attribute_hsv_color_engine_top import lhce_pkg::*;;

    localparam logic [APB_AW-1:0] BASE_EP_ADDR = APB_AW'({REG_BASE_EP, 2'b00});
    // longest quiet stretch: sink hold-off plus one pass through the block plus a long gap
    localparam int SINK_HOLD   = 400;
    localparam int IDLE_LIMIT  = 4000;
    localparam int DRAIN_SLACK = 40;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tready = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_AW-1:0]     paddr = '0;
    logic [APB_DW-1:0]     pwdata = '0;
    logic                  pressure_go = 1'b0;

    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [OUT_USER_W-1:0] o_m_axis_tuser;
    logic [APB_DW-1:0]     o_prdata;
    logic                  o_pready;

    int                    mismatches;
    int                    outstanding;
    int                    idle_cycles = 0;
    logic [7:0]            base_now = BASE_EP_RST;  // base endpoint as last written
    logic                  gap_on = 1'b1;

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    light_attribute_hsv_color_engine_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_prdata        (o_prdata),
        .o_pready        (o_pready)
    );

    hsv_colour_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .i_m_axis_tuser  (o_m_axis_tuser),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (o_pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_item attr_word(input logic [7:0] ep, input logic [15:0] cl,
                                        input logic [15:0] attr, input logic [7:0] ty,
                                        input logic pres, input logic [7:0] val,
                                        input logic ok);
        t_item it;
        it.status_ok     = ok;
        it.endpoint      = ep;
        it.cluster_id    = cl;
        it.attribute_id  = attr;
        it.data_type     = ty;
        it.value_present = pres;
        it.value         = val;
        return it;
    endfunction

    // mostly well-formed writes to live channels with random content,
    // the rest broken writes and pure noise
    function automatic t_item random_word();
        t_item      it;
        int         r;
        logic [7:0] val;
        r   = $urandom_range(0, 99);
        val = 8'($urandom);
        case ($urandom_range(0, 3))
            0: begin
                // keep lamps on most of the time so colours are exercised
                if ($urandom_range(0, 3) == 0) val = 8'd0;
                it = attr_word(8'd0, CL_ON_OFF, ATTR_MAIN, TYPE_BOOL, 1'b1, val, 1'b1);
            end
            1: it = attr_word(8'd0, CL_LEVEL, ATTR_MAIN, TYPE_U8, 1'b1, val, 1'b1);
            2: it = attr_word(8'd0, CL_COLOUR, ATTR_MAIN, TYPE_U8, 1'b1, val, 1'b1);
            default: it = attr_word(8'd0, CL_COLOUR, ATTR_SAT, TYPE_U8, 1'b1, val, 1'b1);
        endcase
        it.endpoint      = base_now + 8'($urandom_range(0, NUM_CHANNELS - 1));
        it.value_present = ($urandom_range(0, 9) != 0);
        it.status_ok     = ($urandom_range(0, 19) != 0);
        if (r >= 90) begin
            it = attr_word(8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                           1'($urandom), 8'($urandom), 1'($urandom));
        end else if (r >= 75) begin
            // one field spoilt
            case ($urandom_range(0, 3))
                0: it.endpoint     = 8'($urandom);
                1: it.cluster_id   = it.cluster_id ^ (16'd1 << $urandom_range(0, 15));
                2: it.attribute_id = 16'($urandom);
                default: it.data_type = 8'($urandom);
            endcase
        end
        return it;
    endfunction

    // called at a clock edge; returns at the edge on which the word is taken
    task automatic send_word(input t_item it);
        int gap;
        gap = gap_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.value, it.data_type, it.attribute_id, it.cluster_id, it.endpoint};
        s_tuser  <= {it.value_present, it.status_ok};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    // every word yields a colour word, so no expectation pending means the block is idle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic write_base(input logic [7:0] ep);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= BASE_EP_ADDR;
        pwdata  <= {24'd0, ep};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        base_now = ep;
    endtask

    task automatic random_phase(input int count, input int hold_at);
        for (int n = 0; n < count; n++) begin
            // stretches with and without sender gaps
            if (n % 64 == 0) gap_on = ($urandom_range(0, 2) != 0);
            if (n == hold_at) pressure_go <= 1'b1;
            send_word(random_word());
        end
    endtask

    // result sink: random stalls, quiet stretches and one long hold-off
    initial begin : sink
        int   stall;
        int   hold;
        logic quiet;
        logic held;
        stall = 0;
        hold  = 0;
        quiet = 1'b0;
        held  = 1'b0;
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 149) == 0) quiet = !quiet;
            if (pressure_go && !held) begin
                held = 1'b1;
                hold = SINK_HOLD;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                stall = quiet ? 0 : pick_gap();
            end
        end
    end

    // watchdog: cycles in a row with no word taken on either side
    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [7:0] hue_pts [8];
        hue_pts = '{8'd0, 8'd43, 8'd85, 8'd127, 8'd170, 8'd212, 8'd254, 8'd255};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words on the reset base endpoint
        gap_on = 1'b0;
        // level write while the lamp is still off: black but changed
        send_word(attr_word(base_now, CL_LEVEL, ATTR_MAIN, TYPE_U8, 1'b1, 8'hFF, 1'b1));
        send_word(attr_word(base_now, CL_ON_OFF, ATTR_MAIN, TYPE_BOOL, 1'b1, 8'h01, 1'b1));
        // every hue sector, including hue past 254 folding into the last sector
        foreach (hue_pts[k])
            send_word(attr_word(base_now, CL_COLOUR, ATTR_MAIN, TYPE_U8, 1'b1, hue_pts[k],
                                1'b1));
        send_word(attr_word(base_now, CL_COLOUR, ATTR_SAT, TYPE_U8, 1'b1, 8'h00, 1'b1));
        send_word(attr_word(base_now, CL_COLOUR, ATTR_SAT, TYPE_U8, 1'b1, 8'hFF, 1'b1));
        // no value attached: stored hue kept but still reported
        send_word(attr_word(base_now, CL_COLOUR, ATTR_MAIN, TYPE_U8, 1'b0, 8'h55, 1'b1));
        send_word(attr_word(base_now, CL_LEVEL, ATTR_MAIN, TYPE_U8, 1'b1, 8'h00, 1'b1));
        // second channel: any nonzero boolean means on
        send_word(attr_word(base_now + 8'd1, CL_ON_OFF, ATTR_MAIN, TYPE_BOOL, 1'b1, 8'h80,
                            1'b1));
        send_word(attr_word(base_now + 8'd1, CL_LEVEL, ATTR_MAIN, TYPE_U8, 1'b0, 8'h00,
                            1'b1));
        send_word(attr_word(base_now, CL_ON_OFF, ATTR_MAIN, TYPE_BOOL, 1'b1, 8'h00, 1'b1));
        // failed status with every other field set
        send_word(attr_word(8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 8'hFF, 1'b0));
        // endpoints either side of the channel window
        send_word(attr_word(base_now - 8'd1, CL_LEVEL, ATTR_MAIN, TYPE_U8, 1'b1, 8'h11,
                            1'b1));
        send_word(attr_word(base_now + 8'd2, CL_LEVEL, ATTR_MAIN, TYPE_U8, 1'b1, 8'h22,
                            1'b1));
        // known endpoint, wrong cluster, attribute or type
        send_word(attr_word(base_now, 16'h1234, ATTR_MAIN, TYPE_U8, 1'b1, 8'h33, 1'b1));
        send_word(attr_word(base_now, CL_COLOUR, 16'h0002, TYPE_U8, 1'b1, 8'h44, 1'b1));
        send_word(attr_word(base_now, CL_LEVEL, ATTR_SAT, TYPE_U8, 1'b1, 8'h44, 1'b1));
        send_word(attr_word(base_now + 8'd1, CL_LEVEL, ATTR_MAIN, TYPE_BOOL, 1'b1, 8'h44,
                            1'b1));
        send_word(attr_word(base_now + 8'd1, CL_ON_OFF, ATTR_MAIN, TYPE_U8, 1'b1, 8'h00,
                            1'b1));
        send_word(attr_word(base_now + 8'd1, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 8'hFF, 1'b1));
        send_word(attr_word(base_now, CL_ON_OFF, ATTR_MAIN, TYPE_BOOL, 1'b1, 8'hFF, 1'b1));

        random_phase(150, -1);

        // base endpoint at its extremes, then somewhere in between
        wait_drained();
        write_base(8'd0);
        random_phase(200, 50);
        wait_drained();
        // channel one wraps round to endpoint zero
        write_base(8'd255);
        random_phase(200, -1);
        wait_drained();
        write_base(8'($urandom_range(1, 254)));
        random_phase(200, -1);

        wait_drained();
        repeat (DRAIN_SLACK) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/lhce_pkg.sv
rtl/lhce_chan.sv
rtl/lhce_huediv.sv
rtl/lhce_smul.sv
rtl/light_attribute_hsv_color_engine_top.sv
rtl/lhce_checker.sv
bench/hsv_colour_checker.sv
bench/tb_light_attribute_hsv_color_engine_top.sv
